### design/assert_macros.svh
// Assertion macros shared by the design files.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge while out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition never holds while out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

### design/ped_pkg.sv
`timescale 1ns / 1ps

package ped_pkg;

    localparam int MAX_PATTERN_CHARS_DEF = 256;
    localparam logic [8:0] COUNT_MAX = 9'd511;

    // decoder modes
    localparam logic [3:0] MODE_NORMAL = 4'd0;
    localparam logic [3:0] MODE_ESC    = 4'd1;
    localparam logic [3:0] MODE_X1     = 4'd2;
    localparam logic [3:0] MODE_X2     = 4'd3;
    localparam logic [3:0] MODE_M1     = 4'd4;
    localparam logic [3:0] MODE_M2     = 4'd5;
    localparam logic [3:0] MODE_M3     = 4'd6;
    localparam logic [3:0] MODE_M4     = 4'd7;
    localparam logic [3:0] MODE_IL     = 4'd8;
    localparam logic [3:0] MODE_SKIP   = 4'd9;

    // result status codes
    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_END   = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    typedef struct packed {
        logic [3:0] mode;
        logic [7:0] partial_byte;
        logic [8:0] bytes_out;
    } ped_state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic [8:0] byte_count;
    } ped_result_t;

endpackage

### design/pattern_escape_decoder.sv
`timescale 1ns / 1ps

// Pattern escape decoder: takes one pattern character per transaction on the
// s_ channel and returns at most one decoded result per character on the m_
// channel. One character is accepted every clock cycle when m_tready stays
// high. A character is held in the input register at the edge that accepts
// it; the decode logic then loads its result into the output register once
// that register is free or being drained, which raises m_tvalid. The decoder
// state and character counter registers form the only loop, which sets that
// rate. Characters inside an escape, other than the one that completes it,
// and all characters skipped after an error, produce no result. m_tuser
// carries the status: data byte, pattern ended ok, or error. A terminator
// (NUL, LF, CR, TAB) ends a pattern and clears all counters.
`include "assert_macros.svh"

module pattern_escape_decoder #(
    parameter int MAX_PATTERN_CHARS = ped_pkg::MAX_PATTERN_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [16:8] byte_count, [23:17] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int CW = $clog2(MAX_PATTERN_CHARS + 1);

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_ch_reg;

    // decoder state
    ped_pkg::ped_state_t st_reg, st_next;
    logic [CW-1:0]       chars_reg, chars_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    ped_pkg::ped_result_t out_reg;

    logic                 advance;
    logic                 fire;
    logic                 res_valid;
    ped_pkg::ped_result_t res;

    // Advance the decode stage whenever the output register is free or
    // being drained this cycle.
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    ped_decode #(
        .MAX_PATTERN_CHARS (MAX_PATTERN_CHARS),
        .CW                (CW)
    ) u_decode (
        .ch              (in_ch_reg),
        .st              (st_reg),
        .chars_seen      (chars_reg),
        .st_next         (st_next),
        .chars_seen_next (chars_next),
        .res_valid       (res_valid),
        .res             (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready)
            in_valid_next = s_tvalid;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = fire && res_valid;
    end

    // Control state and decoder state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
            chars_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire) begin
                st_reg    <= st_next;
                chars_reg <= chars_next;
            end
        end
    end

    // Payload registers: load the character on accept, the result on decode.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready)
            in_ch_reg <= s_tdata;
        if (fire && res_valid)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.byte_count, out_reg.out_byte};
    assign m_tuser  = out_reg.status;

    // Status code three is never produced.
    `ASSERT_NEVER(a_status_code, aclk, aresetn, m_tvalid && m_tuser == 2'd3)

    // End and error results carry a zero data byte.
    `ASSERT_CLK(a_end_zero_byte, aclk, aresetn,
        m_tvalid && m_tuser != ped_pkg::ST_DATA |-> m_tdata[7:0] == 8'h00)

    // A pattern that ends cleanly clears the byte counter.
    `ASSERT_CLK(a_end_clears, aclk, aresetn,
        fire && res_valid && res.status == ped_pkg::ST_END |=> st_reg.bytes_out == 9'd0)

    // The character counter saturates at the pattern limit.
    `ASSERT_NEVER(a_chars_limit, aclk, aresetn, chars_reg > CW'(MAX_PATTERN_CHARS))

endmodule

### design/ped_decode.sv
`timescale 1ns / 1ps

module ped_decode #(
    parameter int MAX_PATTERN_CHARS = ped_pkg::MAX_PATTERN_CHARS_DEF,
    parameter int CW = $clog2(MAX_PATTERN_CHARS + 1)
) (
    input  logic [7:0]          ch,
    input  ped_pkg::ped_state_t st,
    input  logic [CW-1:0]       chars_seen,
    output ped_pkg::ped_state_t st_next,
    output logic [CW-1:0]       chars_seen_next,
    output logic                res_valid,
    output ped_pkg::ped_result_t res
);

    logic       term;
    logic [7:0] lc;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_letter;
    logic       esc_known;
    logic [7:0] esc_byte;
    logic       do_emit;
    logic       do_error;
    logic [7:0] emit_val;
    logic [8:0] bytes_inc;

    assign term = (ch == 8'h00) || (ch == 8'h0A) || (ch == 8'h0D) || (ch == 8'h09);
    assign lc   = ch | 8'h20;

    // hex digit: 0-9 or a-f in either case
    always_comb begin
        is_hex  = 1'b0;
        hex_val = 4'd0;
        if (ch > 8'h2f && ch < 8'h3a) begin
            is_hex  = 1'b1;
            hex_val = ch[3:0];
        end else if (lc > 8'h60 && lc < 8'h67) begin
            is_hex  = 1'b1;
            hex_val = lc[3:0] + 4'd9;
        end
    end

    assign is_letter = (lc >= 8'h61) && (lc <= 8'h7a);
    assign bytes_inc = (st.bytes_out < ped_pkg::COUNT_MAX) ? st.bytes_out + 9'd1
                                                           : st.bytes_out;

    // single-letter escapes
    always_comb begin
        esc_known = 1'b1;
        esc_byte  = 8'h00;
        unique case (ch)
            8'h2A: esc_byte = 8'h2A;  // '*'
            8'h73: esc_byte = 8'h20;  // 's'
            8'h5C: esc_byte = 8'h5C;  // backslash
            8'h72: esc_byte = 8'h0D;  // 'r'
            8'h6E: esc_byte = 8'h0A;  // 'n'
            8'h74: esc_byte = 8'h09;  // 't'
            8'h30: esc_byte = 8'h00;  // '0'
            8'h62: esc_byte = 8'h08;  // 'b'
            8'h61: esc_byte = 8'h07;  // 'a'
            8'h71: esc_byte = 8'h3F;  // 'q'
            8'h53: esc_byte = 8'h27;  // 'S'
            default: esc_known = 1'b0;
        endcase
    end

    always_comb begin
        st_next         = st;
        chars_seen_next = chars_seen;
        res_valid       = 1'b0;
        res.out_byte    = 8'h00;
        res.status      = ped_pkg::ST_DATA;
        res.byte_count  = st.bytes_out;
        do_emit         = 1'b0;
        do_error        = 1'b0;
        emit_val        = 8'h00;

        priority if (st.mode == ped_pkg::MODE_SKIP) begin
            if (term) begin
                st_next         = '0;
                chars_seen_next = '0;
            end
        end else if (term) begin
            res_valid  = 1'b1;
            res.status = (st.mode == ped_pkg::MODE_NORMAL) ? ped_pkg::ST_END
                                                           : ped_pkg::ST_ERROR;
            st_next         = '0;
            chars_seen_next = '0;
        end else if (st.mode == ped_pkg::MODE_NORMAL &&
                     chars_seen >= CW'(MAX_PATTERN_CHARS)) begin
            do_error = 1'b1;
        end else begin
            if (chars_seen < CW'(MAX_PATTERN_CHARS))
                chars_seen_next = chars_seen + CW'(1);
            unique case (st.mode)
                ped_pkg::MODE_ESC: begin
                    priority if (ch == 8'h78) st_next.mode = ped_pkg::MODE_X1;
                    else if (ch == 8'h6D) st_next.mode = ped_pkg::MODE_M1;
                    else if (ch == 8'h69) st_next.mode = ped_pkg::MODE_IL;
                    else if (esc_known) begin
                        do_emit  = 1'b1;
                        emit_val = esc_byte;
                    end else begin
                        do_error = 1'b1;
                    end
                end
                ped_pkg::MODE_X1, ped_pkg::MODE_M1: begin
                    if (!is_hex) begin
                        do_error = 1'b1;
                    end else begin
                        st_next.partial_byte = {hex_val, 4'h0};
                        st_next.mode = (st.mode == ped_pkg::MODE_X1) ? ped_pkg::MODE_X2
                                                                     : ped_pkg::MODE_M2;
                    end
                end
                ped_pkg::MODE_X2: begin
                    if (!is_hex) begin
                        do_error = 1'b1;
                    end else begin
                        do_emit  = 1'b1;
                        emit_val = st.partial_byte | {4'h0, hex_val};
                    end
                end
                ped_pkg::MODE_M2: begin
                    if (!is_hex) begin
                        do_error = 1'b1;
                    end else begin
                        st_next.partial_byte = st.partial_byte | {4'h0, hex_val};
                        st_next.mode = ped_pkg::MODE_M3;
                    end
                end
                ped_pkg::MODE_M3: begin
                    if (!is_hex) do_error = 1'b1;
                    else st_next.mode = ped_pkg::MODE_M4;
                end
                ped_pkg::MODE_M4: begin
                    // mask digits are checked, then dropped
                    if (!is_hex) begin
                        do_error = 1'b1;
                    end else begin
                        do_emit  = 1'b1;
                        emit_val = st.partial_byte;
                    end
                end
                ped_pkg::MODE_IL: begin
                    if (!is_letter) begin
                        do_error = 1'b1;
                    end else begin
                        do_emit  = 1'b1;
                        emit_val = ch;
                    end
                end
                default: begin
                    if (ch == 8'h5C) begin
                        st_next.mode = ped_pkg::MODE_ESC;
                    end else begin
                        do_emit  = 1'b1;
                        emit_val = (ch == 8'h2A) ? 8'h00 : ch;
                    end
                end
            endcase
        end

        if (do_emit) begin
            st_next.mode         = ped_pkg::MODE_NORMAL;
            st_next.partial_byte = 8'h00;
            st_next.bytes_out    = bytes_inc;
            res_valid            = 1'b1;
            res.out_byte         = emit_val;
            res.byte_count       = bytes_inc;
        end
        if (do_error) begin
            st_next.mode         = ped_pkg::MODE_SKIP;
            st_next.partial_byte = 8'h00;
            res_valid            = 1'b1;
            res.status           = ped_pkg::ST_ERROR;
        end
    end

endmodule

### test/pattern_escape_decoder_test.sv
`timescale 1ns / 1ps

module pattern_escape_decoder_test;

    import ped_pkg::*;

    localparam int MAX_CHARS = MAX_PATTERN_CHARS_DEF;
    localparam int RANDOM_CHARS = 520;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] ch
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [7:0] out_byte, [16:8] byte_count, [23:17] zero
    logic [1:0]  m_tuser;            // [1:0] status

    pattern_escape_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Decoder state mirror and the byte stream it predicts
    // ------------------------------------------------------------------
    logic [3:0]  dec_mode = MODE_NORMAL;
    logic [7:0]  hex_acc  = 8'h00;
    int unsigned char_cnt = 0;
    logic [8:0]  byte_cnt = 9'd0;

    ped_result_t decoded_queue[$];
    int          mismatch_count = 0;
    int          chars_sent     = 0;   // characters not swallowed by an error skip
    int          burst_left     = 0;

    function automatic bit is_terminator(input logic [7:0] c);
        return (c == 8'h00 || c == 8'h0A || c == 8'h0D || c == 8'h09);
    endfunction

    function automatic bit hex_value(input logic [7:0] c, output logic [3:0] v);
        logic [7:0] lc;
        lc = c | 8'h20;
        v  = 4'd0;
        if (c >= "0" && c <= "9") begin
            v = 4'(c - 8'h30);
            return 1'b1;
        end
        if (lc >= "a" && lc <= "f") begin
            v = 4'(lc - 8'h61 + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void clear_pattern();
        dec_mode  = MODE_NORMAL;
        hex_acc   = 8'h00;
        char_cnt  = 0;
        byte_cnt  = 9'd0;
    endfunction

    function automatic bit emit_byte(input logic [7:0] b, output ped_result_t r);
        if (byte_cnt < COUNT_MAX)
            byte_cnt++;
        dec_mode     = MODE_NORMAL;
        hex_acc      = 8'h00;
        r.out_byte   = b;
        r.status     = ST_DATA;
        r.byte_count = byte_cnt;
        return 1'b1;
    endfunction

    function automatic bit flag_error(output ped_result_t r);
        dec_mode     = MODE_SKIP;
        hex_acc      = 8'h00;
        r.out_byte   = 8'h00;
        r.status     = ST_ERROR;
        r.byte_count = byte_cnt;
        return 1'b1;
    endfunction

    // Advance the mirror by one character; return 1 when a result is due.
    function automatic bit decode_char(input logic [7:0] c, output ped_result_t r);
        logic [3:0] v;
        logic [7:0] lc;
        r  = '0;
        lc = c | 8'h20;
        if (dec_mode == MODE_SKIP) begin
            // swallow everything after an error until the pattern ends
            if (is_terminator(c))
                clear_pattern();
            return 1'b0;
        end
        if (is_terminator(c)) begin
            r.status     = (dec_mode == MODE_NORMAL) ? ST_END : ST_ERROR;
            r.byte_count = byte_cnt;
            clear_pattern();
            return 1'b1;
        end
        // a new token past the length limit is an error; escape tails still count
        if (dec_mode == MODE_NORMAL && char_cnt >= MAX_CHARS)
            return flag_error(r);
        if (char_cnt < MAX_CHARS)
            char_cnt++;

        case (dec_mode)
            MODE_ESC: begin
                case (c)
                    "x": begin dec_mode = MODE_X1; return 1'b0; end
                    "m": begin dec_mode = MODE_M1; return 1'b0; end
                    "i": begin dec_mode = MODE_IL; return 1'b0; end
                    "*":   return emit_byte(8'h2A, r);
                    "s":   return emit_byte(8'h20, r);
                    8'h5C: return emit_byte(8'h5C, r);   // escaped backslash
                    "r":   return emit_byte(8'h0D, r);
                    "n":   return emit_byte(8'h0A, r);
                    "t":   return emit_byte(8'h09, r);
                    "0":   return emit_byte(8'h00, r);
                    "b":   return emit_byte(8'h08, r);
                    "a":   return emit_byte(8'h07, r);
                    "q":   return emit_byte(8'h3F, r);
                    "S":   return emit_byte(8'h27, r);
                    default: return flag_error(r);
                endcase
            end
            MODE_X1, MODE_M1: begin
                if (!hex_value(c, v))
                    return flag_error(r);
                hex_acc  = {v, 4'h0};
                dec_mode = (dec_mode == MODE_X1) ? MODE_X2 : MODE_M2;
                return 1'b0;
            end
            MODE_X2: begin
                if (!hex_value(c, v))
                    return flag_error(r);
                return emit_byte(hex_acc | {4'h0, v}, r);
            end
            MODE_M2: begin
                if (!hex_value(c, v))
                    return flag_error(r);
                hex_acc  = hex_acc | {4'h0, v};
                dec_mode = MODE_M3;
                return 1'b0;
            end
            MODE_M3: begin
                // mask digits are checked, never kept
                if (!hex_value(c, v))
                    return flag_error(r);
                dec_mode = MODE_M4;
                return 1'b0;
            end
            MODE_M4: begin
                if (!hex_value(c, v))
                    return flag_error(r);
                return emit_byte(hex_acc, r);
            end
            MODE_IL: begin
                if (lc > "z" || lc < "a")
                    return flag_error(r);
                return emit_byte(c, r);
            end
            default: begin
                if (c == 8'h5C) begin
                    dec_mode = MODE_ESC;
                    return 1'b0;
                end
                return emit_byte((c == "*") ? 8'h00 : c, r);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver: stall on a pattern of its own, switching style now and then
    // ------------------------------------------------------------------
    int         stall_style = 0;
    int         stall_left  = 0;
    logic [7:0] ready_rot   = 8'b1011_0010;

    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_style <= $urandom_range(0, 3);
            stall_left  <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        ready_rot <= {ready_rot[6:0], ready_rot[7]};
        case (stall_style)
            0:       m_tready <= 1'b1;                          // no back-pressure
            1:       m_tready <= ($urandom_range(0, 99) < 70);
            2:       m_tready <= ready_rot[0];                  // fixed rotating mask
            default: m_tready <= ($urandom_range(0, 99) < 25);  // heavy stall
        endcase
    end

    // ------------------------------------------------------------------
    // Result checker: compare each transaction with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        ped_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_queue.size() == 0) begin
                $display("%0t: result with nothing predicted: out_byte %02h status %0d count %0d",
                         $time, m_tdata[7:0], m_tuser, m_tdata[16:8]);
                mismatch_count++;
            end else begin
                want = decoded_queue.pop_front();
                if (m_tuser !== want.status) begin
                    $display("%0t: status expected %0d, actual %0d",
                             $time, want.status, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[7:0] !== want.out_byte) begin
                    $display("%0t: out_byte expected %02h, actual %02h",
                             $time, want.out_byte, m_tdata[7:0]);
                    mismatch_count++;
                end
                if (m_tdata[16:8] !== want.byte_count) begin
                    $display("%0t: byte_count expected %0d, actual %0d",
                             $time, want.byte_count, m_tdata[16:8]);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Drive one character in bursts with random gaps; predict on acceptance.
    task automatic send_char(input logic [7:0] c);
        int          gap;
        bit          was_skipping;
        ped_result_t r;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 30);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        was_skipping = (dec_mode == MODE_SKIP);
        if (decode_char(c, r))
            decoded_queue.push_back(r);
        if (!was_skipping)
            chars_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i]);
    endtask

    // Hold the sender off until every predicted result has been drained.
    task automatic hold_until_drained();
        int guard;
        guard      = 0;
        burst_left = 0;
        s_tvalid  <= 1'b0;
        @(posedge aclk);
        while (decoded_queue.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
    endtask

    function automatic logic [7:0] pick_hex();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] pick_letter();
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] pick_terminator();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'h0A;
            2:       return 8'h0D;
            default: return 8'h09;
        endcase
    endfunction

    // any byte that is neither a terminator nor an escape start
    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (is_terminator(c) || c == 8'h5C)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // One token of the pattern language; a few are deliberately broken.
    task automatic send_token(input bit allow_broken);
        int         kind;
        string      table_letters;
        logic [3:0] v;
        logic [7:0] c;
        table_letters = "*s\\rnt0baqS";
        kind = $urandom_range(0, 99);
        if (allow_broken && kind < 6) begin
            send_char(8'h5C);
            case ($urandom_range(0, 3))
                0: send_char(8'($urandom_range(0, 255)));   // arbitrary escape letter
                1: begin
                    send_char("x");
                    c = 8'($urandom_range(0, 255));
                    while (hex_value(c, v)) c = 8'($urandom_range(0, 255));
                    send_char(c);
                end
                2: begin
                    send_char("i");
                    c = 8'($urandom_range(0, 255));
                    while ((c | 8'h20) >= "a" && (c | 8'h20) <= "z")
                        c = 8'($urandom_range(0, 255));
                    send_char(c);
                end
                default: begin
                    // break a masked escape somewhere after its first hex digit
                    send_char("m");
                    repeat ($urandom_range(1, 3)) send_char(pick_hex());
                    send_char(8'($urandom_range(0, 255)));
                end
            endcase
        end else if (kind < 45) begin
            send_char(pick_plain());
        end else if (kind < 60) begin
            send_char(8'h5C);
            send_char(table_letters[$urandom_range(0, 10)]);
        end else if (kind < 72) begin
            send_text("\\x");
            send_char(pick_hex());
            send_char(pick_hex());
        end else if (kind < 84) begin
            send_text("\\m");
            repeat (4) send_char(pick_hex());
        end else if (kind < 92) begin
            send_text("\\i");
            send_char(pick_letter());
        end else begin
            send_char("*");
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Wildcard, high bytes, each escape family and a clean end.
    task automatic test_basic_tokens();
        send_char("*");
        send_char(8'hFF);
        send_char(8'h80);
        send_text("\\x4F\\m3Ac0\\iQ\\S");
        send_char(8'h0A);
    endtask

    // Bad escape letter with skipped tail, then a pattern cut inside an escape.
    task automatic test_error_paths();
        send_text("\\zab");
        send_char(8'h0D);
        send_text("\\x");
        send_char(8'h00);
    endtask

    // Patterns at and past the length limit.
    task automatic test_long_patterns();
        int target;
        int n;
        // exactly at the limit, then a clean end
        repeat (MAX_CHARS) send_char(pick_plain());
        send_char(pick_terminator());
        // escape begun on the last allowed character finishes; next token fails
        repeat (MAX_CHARS - 1) send_char(pick_plain());
        send_text("\\x41A");
        send_char(pick_terminator());
        // random length around the limit, with escapes straddling it
        target = $urandom_range(MAX_CHARS - 6, MAX_CHARS + 6);
        n      = 0;
        while (n < target) begin
            if ($urandom_range(0, 7) == 0) begin
                send_text("\\s");
                n += 2;
            end else begin
                send_char(pick_plain());
                n++;
            end
        end
        send_char(pick_terminator());
        hold_until_drained();
    endtask

    // Mostly well-formed short patterns, with noise and broken escapes mixed in.
    task automatic test_random_patterns();
        int start_count;
        start_count = chars_sent;
        while (chars_sent - start_count < RANDOM_CHARS) begin
            if ($urandom_range(0, 14) == 0) begin
                repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(0, 12)) send_token(1'b1);
            end
            if ($urandom_range(0, 9) != 0)
                send_char(pick_terminator());
            // occasionally let the pipeline empty completely
            if ($urandom_range(0, 9) == 0)
                hold_until_drained();
        end
    endtask

    initial begin
        clear_pattern();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_basic_tokens();
        test_error_paths();
        hold_until_drained();
        test_long_patterns();
        test_random_patterns();

        // drain, then allow the two-stage pipeline to settle
        hold_until_drained();
        repeat (8) @(posedge aclk);

        if (decoded_queue.size() != 0) begin
            $display("%0t: %0d predicted results never arrived", $time, decoded_queue.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
